[hdl/tlfd_pkg.sv]
// shared types and constants for the typed length frame deframer
package tlfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 21;
  localparam int unsigned ACC_W = 32;
  localparam int unsigned PHASE_W = 3;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [PHASE_W-1:0] PHASE_TYPE = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST_LEN = 3'd4;

  localparam logic [ACC_W-1:0] ERROR_FRAME_LEN = 32'd4;
  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_COMMAND = 2'd1,
    KIND_EMPTY   = 2'd2,
    KIND_DESYNC  = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAZE_TYPE    = 3'd0,
    REG_STATUS_TYPE  = 3'd1,
    REG_RESP_TYPE    = 3'd2,
    REG_DISP_TYPE    = 3'd3,
    REG_ERROR_TYPE   = 3'd4,
    REG_GAZE_LEN     = 3'd5,
    REG_STATUS_MIN   = 3'd6,
    REG_MAX_LEN      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] gaze_type;
    logic [BYTE_W-1:0] status_type;
    logic [BYTE_W-1:0] resp_type;
    logic [BYTE_W-1:0] disp_type;
    logic [BYTE_W-1:0] error_type;
    logic [LEN_W-1:0]  gaze_len;
    logic [LEN_W-1:0]  status_min;
    logic [LEN_W-1:0]  max_len;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gaze_type:   8'd0,
    status_type: 8'd1,
    resp_type:   8'd2,
    disp_type:   8'd3,
    error_type:  8'd4,
    gaze_len:    21'd64,
    status_min:  21'd3,
    max_len:     21'd65536
  };

endpackage

[hdl/typed_length_frame_deframer.sv]
// typed length frame deframer top level
// results: each is registered and appears in the cycle after the item that causes it
// throughput: one item per cycle while in_stall_o is low; header parse, length check and payload count
//   are each done in one pass between the input and the result register
// reset: asynchronous active low; returns to header wait and restores register defaults
module typed_length_frame_deframer (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tlfd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tlfd_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [tlfd_pkg::BYTE_W-1:0]         data_byte_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          kind_o,
  output logic [tlfd_pkg::BYTE_W-1:0]         byte_value_o,
  output logic [tlfd_pkg::BYTE_W-1:0]         frame_type_o,
  output logic [tlfd_pkg::BYTE_W-1:0]         command_code_o,
  output logic [tlfd_pkg::LEN_W-1:0]          payload_length_o,
  output logic                                last_of_frame_o
);
  import tlfd_pkg::*;

  cfg_t cfg_q;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               in_payload_q, in_payload_d;
  logic [BYTE_W-1:0]  type_q, type_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [LEN_W-1:0]   rem_q, rem_d;
  logic               first_q, first_d;
  logic [BYTE_W-1:0]  cmd_q, cmd_d;

  logic               out_valid_q;
  kind_e              kind_q, kind_d;
  logic [BYTE_W-1:0]  val_q, val_d;
  logic [BYTE_W-1:0]  ftype_q;
  logic [BYTE_W-1:0]  ocmd_q, ocmd_d;
  logic [LEN_W-1:0]   olen_q, olen_d;
  logic               last_q, last_d;
  logic               res_valid;

  logic               accept;
  logic [1:0]         phase_m1;
  logic [ACC_W-1:0]   acc_new;
  logic               len_ok;
  logic               is_resp;
  logic [LEN_W-1:0]   rem_dec;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_GAZE_TYPE:   cfg_q.gaze_type   <= cfg_data_i[BYTE_W-1:0];
        REG_STATUS_TYPE: cfg_q.status_type <= cfg_data_i[BYTE_W-1:0];
        REG_RESP_TYPE:   cfg_q.resp_type   <= cfg_data_i[BYTE_W-1:0];
        REG_DISP_TYPE:   cfg_q.disp_type   <= cfg_data_i[BYTE_W-1:0];
        REG_ERROR_TYPE:  cfg_q.error_type  <= cfg_data_i[BYTE_W-1:0];
        REG_GAZE_LEN:    cfg_q.gaze_len    <= cfg_data_i;
        REG_STATUS_MIN:  cfg_q.status_min  <= cfg_data_i;
        REG_MAX_LEN:     cfg_q.max_len     <= cfg_data_i;
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // length bytes arrive least significant first
  assign phase_m1 = 2'(phase_q - 3'd1);
  assign acc_new  = acc_q | ({{(ACC_W-BYTE_W){1'b0}}, data_byte_i} << {phase_m1, 3'b000});
  assign is_resp  = type_q == cfg_q.resp_type;
  assign rem_dec  = rem_q - LEN_W'(1);

  tlfd_len_check u_len_check (
    .cfg_i  (cfg_q),
    .type_i (type_q),
    .len_i  (acc_new),
    .ok_o   (len_ok)
  );

  always_comb begin
    phase_d      = phase_q;
    in_payload_d = in_payload_q;
    type_d       = type_q;
    acc_d        = acc_q;
    rem_d        = rem_q;
    first_d      = first_q;
    cmd_d        = cmd_q;
    res_valid    = 1'b0;
    kind_d       = KIND_PAYLOAD;
    val_d        = '0;
    ocmd_d       = '0;
    last_d       = 1'b0;
    if (accept) begin
      if (in_payload_q) begin
        rem_d     = rem_dec;
        last_d    = rem_dec == '0;
        res_valid = 1'b1;
        val_d     = data_byte_i;
        if (is_resp && first_q) begin
          cmd_d  = data_byte_i;
          kind_d = KIND_COMMAND;
          ocmd_d = data_byte_i;
        end else begin
          kind_d = KIND_PAYLOAD;
          ocmd_d = is_resp ? cmd_q : '0;
        end
        first_d = 1'b0;
        if (rem_dec == '0) begin
          in_payload_d = 1'b0;
          phase_d      = PHASE_TYPE;
        end
      end else if (phase_q == PHASE_TYPE) begin
        type_d  = data_byte_i;
        acc_d   = '0;
        cmd_d   = '0;
        first_d = 1'b1;
        phase_d = 3'd1;
      end else begin
        acc_d = acc_new;
        if (phase_q != PHASE_LAST_LEN) begin
          phase_d = phase_q + 3'd1;
        end else begin
          phase_d = PHASE_TYPE;
          if (!len_ok) begin
            res_valid = 1'b1;
            kind_d    = KIND_DESYNC;
            last_d    = 1'b1;
          end else if (acc_new == '0) begin
            res_valid = 1'b1;
            kind_d    = KIND_EMPTY;
            last_d    = 1'b1;
          end else begin
            rem_d        = acc_new[LEN_W-1:0];
            in_payload_d = 1'b1;
            first_d      = 1'b1;
          end
        end
      end
    end
    olen_d = (|acc_d[ACC_W-1:LEN_W]) ? LEN_SAT : acc_d[LEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PHASE_TYPE;
      in_payload_q <= 1'b0;
      type_q       <= '0;
      acc_q        <= '0;
      rem_q        <= '0;
      first_q      <= 1'b1;
      cmd_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      in_payload_q <= in_payload_d;
      type_q       <= type_d;
      acc_q        <= acc_d;
      rem_q        <= rem_d;
      first_q      <= first_d;
      cmd_q        <= cmd_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      kind_q  <= kind_d;
      val_q   <= val_d;
      ftype_q <= type_q;
      ocmd_q  <= ocmd_d;
      olen_q  <= olen_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign byte_value_o     = val_q;
  assign frame_type_o     = ftype_q;
  assign command_code_o   = ocmd_q;
  assign payload_length_o = olen_q;
  assign last_of_frame_o  = last_q;

endmodule

[hdl/tlfd_len_check.sv]
// header length check against the maximum and the per-type rule
module tlfd_len_check (
  input  tlfd_pkg::cfg_t                    cfg_i,
  input  logic [tlfd_pkg::BYTE_W-1:0]       type_i,
  input  logic [tlfd_pkg::ACC_W-1:0]        len_i,
  output logic                              ok_o
);
  import tlfd_pkg::*;

  logic too_long;
  logic rule_ok;

  assign too_long = len_i > {{(ACC_W-LEN_W){1'b0}}, cfg_i.max_len};

  always_comb begin
    if (type_i == cfg_i.gaze_type) begin
      rule_ok = len_i == {{(ACC_W-LEN_W){1'b0}}, cfg_i.gaze_len};
    end else if (type_i == cfg_i.error_type) begin
      rule_ok = len_i == ERROR_FRAME_LEN;
    end else if (type_i == cfg_i.status_type) begin
      rule_ok = len_i >= {{(ACC_W-LEN_W){1'b0}}, cfg_i.status_min};
    end else if (type_i == cfg_i.resp_type) begin
      rule_ok = len_i != '0;
    end else if (type_i == cfg_i.disp_type) begin
      rule_ok = 1'b1;
    end else begin
      rule_ok = 1'b0;
    end
  end

  assign ok_o = !too_long && rule_ok;

endmodule
